### hdl/ppe_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the particle pool emitter.
package ppe_pkg;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_BURST   = 2'd2;

    localparam logic [2:0] CFG_EMIT_MODE    = 3'd0;
    localparam logic [2:0] CFG_SLOTS_IN_USE = 3'd1;
    localparam logic [2:0] CFG_BASE_VEL_X   = 3'd2;
    localparam logic [2:0] CFG_BASE_VEL_Y   = 3'd3;
    localparam logic [2:0] CFG_FADE_BASE    = 3'd4;
    localparam logic [2:0] CFG_GRAVITY_STEP = 3'd5;
    localparam logic [2:0] CFG_BOOT_PERIOD  = 3'd6;
    localparam logic [2:0] CFG_IMP_PERIOD   = 3'd7;

    localparam logic signed [11:0] LIFE_START    = 12'sd1024;
    localparam logic [3:0]         GROUP_WRAP    = 4'd10;
    localparam logic [3:0]         GROUP_RESTART = 4'd2;
    localparam logic [3:0]         GROUP_FIRST   = 4'd1;
    localparam logic signed [7:0]  LIVE_MAX      = 8'sd64;
    localparam logic signed [7:0]  LIVE_MIN      = -8'sd64;

    typedef struct packed {
        logic              active;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [11:0] life;
        logic signed [10:0] fade;
        logic              impure;
        logic [3:0]        group;
    } slot_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [15:0] emitter_x;
        logic signed [15:0] emitter_y;
        logic              stop_generation;
        logic signed [15:0] rand_vel_x;
        logic signed [15:0] rand_vel_y;
        logic signed [4:0]  rand_fade;
    } item_t;

    typedef struct packed {
        logic              tick;
        logic              in_range;
        logic              target;
        logic              spawn_ok;
        logic              impure;
        logic [3:0]        group;
        logic signed [7:0]  live;
        logic signed [15:0] base_vel_x;
        logic signed [15:0] base_vel_y;
        logic [9:0]        fade_base;
        logic signed [8:0]  gravity;
    } unit_ctl_t;

    typedef struct packed {
        logic              spawned;
        logic [3:0]        group;
        logic signed [7:0]  live;
    } unit_sts_t;

endpackage

### hdl/ppe_if.sv
`timescale 1ns / 1ps
// Handshake interfaces for the command and result channels.
interface ppe_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic signed [15:0] emitter_x;
    logic signed [15:0] emitter_y;
    logic              stop_generation;
    logic signed [15:0] rand_vel_x;
    logic signed [15:0] rand_vel_y;
    logic signed [4:0]  rand_fade;

    modport source (output valid, cmd, emitter_x, emitter_y, stop_generation,
                    rand_vel_x, rand_vel_y, rand_fade, input ready);
    modport sink (input valid, cmd, emitter_x, emitter_y, stop_generation,
                  rand_vel_x, rand_vel_y, rand_fade, output ready);
endinterface

interface ppe_rsp_if;
    logic              valid;
    logic              ready;
    logic [4:0]        slot;
    logic              is_active;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [11:0] life_left;
    logic              second_colour;
    logic [3:0]        blend_group;
    logic signed [7:0]  live_count;
    logic              finished;
    logic              last;

    modport source (output valid, slot, is_active, pos_x, pos_y, life_left,
                    second_colour, blend_group, live_count, finished, last,
                    input ready);
    modport sink (input valid, slot, is_active, pos_x, pos_y, life_left,
                  second_colour, blend_group, live_count, finished, last,
                  output ready);
endinterface

### hdl/ppe_cell.sv
`timescale 1ns / 1ps
// One pool slot of the rotating ring of particle cells.
module ppe_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear,
    input  logic            shift,
    input  ppe_pkg::slot_t  d,
    output ppe_pkg::slot_t  q
);

    logic           active_reg;
    ppe_pkg::slot_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (clear)
        begin
            active_reg <= 1'b0;
        end
        else if (shift)
        begin
            active_reg <= d.active;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d;
        end
    end

    always_comb
    begin
        q        = data_reg;
        q.active = active_reg;
    end

endmodule

### hdl/ppe_slot_unit.sv
`timescale 1ns / 1ps
// Update and spawn logic applied to the slot at the head of the ring.
module ppe_slot_unit #(
    parameter int FRAC_BITS = 8
) (
    input  ppe_pkg::slot_t     slot_in,
    input  ppe_pkg::item_t     item,
    input  ppe_pkg::unit_ctl_t ctl,
    output ppe_pkg::slot_t     slot_out,
    output ppe_pkg::unit_sts_t sts
);

    function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
        logic signed [23:0] r;
        begin
            if (v > 40'sd8388607)
                r = 24'sh7FFFFF;
            else if (v < -40'sd8388608)
                r = -24'sh800000;
            else
                r = v[23:0];
            return r;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        begin
            if (v > 17'sd32767)
                r = 16'sh7FFF;
            else if (v < -17'sd32768)
                r = -16'sh8000;
            else
                r = v[15:0];
            return r;
        end
    endfunction

    ppe_pkg::slot_t     spawn;
    ppe_pkg::slot_t     moved;
    logic signed [39:0] ex;
    logic signed [39:0] ey;
    logic signed [11:0] fade_sum;
    logic signed [12:0] life_diff;
    logic signed [11:0] life_new;
    logic [3:0]         group_inc;
    logic signed [7:0]  live_up;
    logic signed [7:0]  live_down;

    always_comb
    begin
        ex = 40'(item.emitter_x) <<< FRAC_BITS;
        ey = 40'(item.emitter_y) <<< FRAC_BITS;
        fade_sum = $signed({2'b00, ctl.fade_base}) + 12'(item.rand_fade);

        spawn.active = 1'b1;
        spawn.pos_x  = sat24(ex);
        spawn.pos_y  = sat24(ey);
        spawn.vel_x  = sat16(17'(ctl.base_vel_x) + 17'(item.rand_vel_x));
        spawn.vel_y  = sat16(17'(ctl.base_vel_y) + 17'(item.rand_vel_y));
        spawn.life   = ppe_pkg::LIFE_START;
        spawn.fade   = (fade_sum > 12'sd1023) ? 11'sd1023 : fade_sum[10:0];
        spawn.impure = ctl.impure;
        spawn.group  = ctl.group;

        life_diff = 13'(slot_in.life) - 13'(slot_in.fade);
        if (life_diff > 13'sd2047)
            life_new = 12'sh7FF;
        else if (life_diff < -13'sd2048)
            life_new = -12'sh800;
        else
            life_new = life_diff[11:0];

        moved        = slot_in;
        moved.pos_x  = sat24(40'(slot_in.pos_x) + 40'(slot_in.vel_x));
        moved.pos_y  = sat24(40'(slot_in.pos_y) + 40'(slot_in.vel_y));
        moved.vel_y  = sat16(17'(slot_in.vel_y) + 17'(ctl.gravity));
        moved.life   = life_new;
        moved.active = (life_new > 12'sd0);

        group_inc = ctl.group + 4'd1;
        live_up   = (ctl.live >= ppe_pkg::LIVE_MAX) ? ppe_pkg::LIVE_MAX : ctl.live + 8'sd1;
        live_down = (ctl.live <= ppe_pkg::LIVE_MIN) ? ppe_pkg::LIVE_MIN : ctl.live - 8'sd1;

        slot_out    = slot_in;
        sts.spawned = 1'b0;
        sts.live    = ctl.live;

        if (ctl.in_range)
        begin
            if (ctl.tick)
            begin
                if (slot_in.active)
                begin
                    slot_out = moved;
                    if (!moved.active)
                        sts.live = live_down;
                end
                else if (ctl.spawn_ok)
                begin
                    slot_out    = spawn;
                    sts.spawned = 1'b1;
                    sts.live    = live_up;
                end
            end
            else if (ctl.target)
            begin
                slot_out    = spawn;
                sts.spawned = 1'b1;
                if (!slot_in.active)
                    sts.live = live_up;
            end
        end

        if (sts.spawned)
            sts.group = (group_inc >= ppe_pkg::GROUP_WRAP) ? ppe_pkg::GROUP_RESTART : group_inc;
        else
            sts.group = ctl.group;
    end

endmodule

### hdl/particle_pool_emitter_tick.sv
`timescale 1ns / 1ps
// Top level: a ring of slot cells rotated past one update unit and then past the result port.
// A tick or burst takes one update lap and then one report lap around the ring,
// and the report lap stalls while the result port holds a beat that is not yet taken.
// A restart, an unused command or a refused burst is handled in the idle state and starts no lap.
// The next command is taken while the final result beat still waits in the output register.
// Reset (rst_n low, asynchronous) empties the pool and loads the register defaults.
module particle_pool_emitter_tick #(
    parameter int POOL_SIZE = 32,
    parameter int FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    ppe_req_if.sink     req,
    ppe_rsp_if.source   rsp
);

    localparam int CW = $clog2(POOL_SIZE + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_UPDATE = 3'b010,
        ST_REPORT = 3'b100
    } state_t;

    logic               emit_mode_reg;
    logic [5:0]         slots_reg;
    logic signed [15:0] base_vel_x_reg;
    logic signed [15:0] base_vel_y_reg;
    logic [9:0]         fade_base_reg;
    logic signed [8:0]  gravity_reg;
    logic [7:0]         boot_period_reg;
    logic [7:0]         imp_period_reg;

    state_t             state_reg, state_next;
    logic [CW-1:0]      k_reg, k_next;
    ppe_pkg::item_t     item_reg;
    logic [7:0]         imp_reg, imp_next;
    logic [7:0]         boot_reg, boot_next;
    logic [3:0]         group_reg, group_next;
    logic signed [7:0]  live_reg, live_next;
    logic               done_reg, done_next;
    logic [CW-1:0]      burst_reg, burst_next;
    logic               open_reg, open_next;

    logic               ov_reg, ov_next;
    logic [4:0]         o_slot_reg;
    logic               o_active_reg;
    logic signed [23:0] o_pos_x_reg;
    logic signed [23:0] o_pos_y_reg;
    logic signed [11:0] o_life_reg;
    logic               o_colour_reg;
    logic [3:0]         o_group_reg;
    logic signed [7:0]  o_live_reg;
    logic               o_done_reg;
    logic               o_last_reg;

    ppe_pkg::slot_t     cell_q [POOL_SIZE];
    ppe_pkg::slot_t     tail_d;
    ppe_pkg::slot_t     head_new;
    ppe_pkg::unit_ctl_t ctl;
    ppe_pkg::unit_sts_t sts;

    logic [6:0]         n_full;
    logic [CW-1:0]      n;
    logic               take;
    logic               shift;
    logic               clear;
    logic               emit;
    logic               load;
    logic               lap_end;
    logic [8:0]         imp_inc;
    logic [8:0]         boot_inc;
    logic [7:0]         imp_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_mode_reg   <= 1'b0;
            slots_reg       <= 6'd32;
            base_vel_x_reg  <= '0;
            base_vel_y_reg  <= '0;
            fade_base_reg   <= 10'd16;
            gravity_reg     <= '0;
            boot_period_reg <= '0;
            imp_period_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppe_pkg::CFG_EMIT_MODE:    emit_mode_reg   <= cfg_data[0];
                ppe_pkg::CFG_SLOTS_IN_USE: slots_reg       <= cfg_data[5:0];
                ppe_pkg::CFG_BASE_VEL_X:   base_vel_x_reg  <= cfg_data;
                ppe_pkg::CFG_BASE_VEL_Y:   base_vel_y_reg  <= cfg_data;
                ppe_pkg::CFG_FADE_BASE:    fade_base_reg   <= cfg_data[9:0];
                ppe_pkg::CFG_GRAVITY_STEP: gravity_reg     <= cfg_data[8:0];
                ppe_pkg::CFG_BOOT_PERIOD:  boot_period_reg <= cfg_data[7:0];
                ppe_pkg::CFG_IMP_PERIOD:   imp_period_reg  <= cfg_data[7:0];
                default:                   emit_mode_reg   <= emit_mode_reg;
            endcase
        end
    end

    assign n_full = ({1'b0, slots_reg} > 7'(POOL_SIZE)) ? 7'(POOL_SIZE) : {1'b0, slots_reg};
    assign n      = CW'(n_full);

    genvar gi;
    generate
        for (gi = 0; gi < POOL_SIZE; gi++)
        begin : g_cell
            ppe_pkg::slot_t d;
            if (gi == POOL_SIZE - 1)
            begin : g_tail
                assign d = tail_d;
            end
            else
            begin : g_mid
                assign d = cell_q[gi + 1];
            end
            ppe_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .clear (clear),
                .shift (shift),
                .d     (d),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        ctl.tick       = (item_reg.cmd == ppe_pkg::CMD_TICK);
        ctl.in_range   = (k_reg < n);
        ctl.target     = (k_reg == burst_reg);
        ctl.spawn_ok   = !item_reg.stop_generation && (boot_reg == 8'd0) && open_reg
                         && !emit_mode_reg;
        ctl.impure     = (imp_reg == 8'd0);
        ctl.group      = group_reg;
        ctl.live       = live_reg;
        ctl.base_vel_x = base_vel_x_reg;
        ctl.base_vel_y = base_vel_y_reg;
        ctl.fade_base  = fade_base_reg;
        ctl.gravity    = gravity_reg;
    end

    ppe_slot_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_unit (
        .slot_in  (cell_q[0]),
        .item     (item_reg),
        .ctl      (ctl),
        .slot_out (head_new),
        .sts      (sts)
    );

    assign tail_d = (state_reg == ST_UPDATE) ? head_new : cell_q[0];

    assign req.ready = (state_reg == ST_IDLE);
    assign take      = req.valid && req.ready;
    assign clear     = take && (req.cmd == ppe_pkg::CMD_RESTART);
    assign lap_end   = (k_reg == CW'(POOL_SIZE - 1));

    always_comb
    begin
        if (item_reg.cmd == ppe_pkg::CMD_TICK)
            emit = (k_reg < n);
        else
            emit = ((k_reg + CW'(1)) == burst_reg);
    end

    assign load = (state_reg == ST_REPORT) && emit && (!ov_reg || rsp.ready);

    always_comb
    begin
        imp_inc  = {1'b0, imp_reg} + 9'd1;
        boot_inc = {1'b0, boot_reg} + 9'd1;
        imp_step = (imp_inc > {1'b0, imp_period_reg}) ? 8'd0 : imp_inc[7:0];

        state_next = state_reg;
        k_next     = k_reg;
        imp_next   = imp_reg;
        boot_next  = boot_reg;
        group_next = group_reg;
        live_next  = live_reg;
        done_next  = done_reg;
        burst_next = burst_reg;
        open_next  = open_reg;
        shift      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (req.cmd == ppe_pkg::CMD_RESTART)
                    begin
                        imp_next   = '0;
                        boot_next  = '0;
                        group_next = ppe_pkg::GROUP_FIRST;
                        live_next  = '0;
                        done_next  = 1'b0;
                        burst_next = '0;
                    end
                    else if (req.cmd == ppe_pkg::CMD_TICK ||
                             (req.cmd == ppe_pkg::CMD_BURST && burst_reg < n))
                    begin
                        state_next = ST_UPDATE;
                        k_next     = '0;
                        open_next  = 1'b1;
                    end
                end
            end
            ST_UPDATE:
            begin
                shift      = 1'b1;
                group_next = sts.group;
                live_next  = sts.live;
                if (sts.spawned)
                    open_next = 1'b0;
                k_next = k_reg + CW'(1);
                if (lap_end)
                begin
                    k_next     = '0;
                    state_next = ST_REPORT;
                    imp_next   = imp_step;
                    if (ctl.tick)
                    begin
                        boot_next = (boot_inc > {1'b0, boot_period_reg}) ? 8'd0 : boot_inc[7:0];
                        if (sts.live == 8'sd0)
                            done_next = 1'b1;
                    end
                    else
                    begin
                        burst_next = burst_reg + CW'(1);
                    end
                end
            end
            ST_REPORT:
            begin
                if (!emit || !ov_reg || rsp.ready)
                begin
                    shift  = 1'b1;
                    k_next = k_reg + CW'(1);
                    if (lap_end)
                    begin
                        k_next     = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        ov_next = ov_reg;
        if (rsp.ready)
            ov_next = 1'b0;
        if (load)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            imp_reg   <= '0;
            boot_reg  <= '0;
            group_reg <= ppe_pkg::GROUP_FIRST;
            live_reg  <= '0;
            done_reg  <= 1'b0;
            burst_reg <= '0;
            open_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            imp_reg   <= imp_next;
            boot_reg  <= boot_next;
            group_reg <= group_next;
            live_reg  <= live_next;
            done_reg  <= done_next;
            burst_reg <= burst_next;
            open_reg  <= open_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.cmd             <= req.cmd;
            item_reg.emitter_x       <= req.emitter_x;
            item_reg.emitter_y       <= req.emitter_y;
            item_reg.stop_generation <= req.stop_generation;
            item_reg.rand_vel_x      <= req.rand_vel_x;
            item_reg.rand_vel_y      <= req.rand_vel_y;
            item_reg.rand_fade       <= req.rand_fade;
        end
        if (load)
        begin
            o_slot_reg   <= 5'(k_reg);
            o_active_reg <= cell_q[0].active;
            o_pos_x_reg  <= cell_q[0].active ? cell_q[0].pos_x : '0;
            o_pos_y_reg  <= cell_q[0].active ? cell_q[0].pos_y : '0;
            o_life_reg   <= cell_q[0].active ? cell_q[0].life : '0;
            o_colour_reg <= cell_q[0].active && cell_q[0].impure;
            o_group_reg  <= cell_q[0].active ? cell_q[0].group : '0;
            o_live_reg   <= live_reg;
            o_done_reg   <= done_reg;
            o_last_reg   <= (item_reg.cmd != ppe_pkg::CMD_TICK) ||
                            (k_reg == n - CW'(1));
        end
    end

    assign rsp.valid         = ov_reg;
    assign rsp.slot          = o_slot_reg;
    assign rsp.is_active     = o_active_reg;
    assign rsp.pos_x         = o_pos_x_reg;
    assign rsp.pos_y         = o_pos_y_reg;
    assign rsp.life_left     = o_life_reg;
    assign rsp.second_colour = o_colour_reg;
    assign rsp.blend_group   = o_group_reg;
    assign rsp.live_count    = o_live_reg;
    assign rsp.finished      = o_done_reg;
    assign rsp.last          = o_last_reg;

endmodule

### tb/particle_pool_emitter_tick_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the particle pool emitter: directed table, then random phases.
module particle_pool_emitter_tick_test;

    localparam int  NSLOT     = 32;
    localparam int  FRAC      = 8;
    localparam int  SETTLE    = 2 * NSLOT + 16;
    localparam int  LIMIT     = 600000;
    localparam int  PHASE_LEN = 24;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [4:0]  slot;
        logic        is_active;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [11:0] life_left;
        logic        second_colour;
        logic [3:0]  blend_group;
        logic [7:0]  live_count;
        logic        finished;
        logic        last;
    } beat_t;

    typedef struct {
        int              new_slots;
        ppe_pkg::item_t  it;
        int              n_beats;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    ppe_req_if req_ch ();
    ppe_rsp_if rsp_ch ();

    particle_pool_emitter_tick #(.POOL_SIZE(NSLOT), .FRAC_BITS(FRAC)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source)
    );

    // Register copy held by the predictor.
    bit     r_mode;
    longint r_slots, r_bvx, r_bvy, r_fade, r_grav, r_boot, r_impp;

    // Pool copy held by the predictor.
    bit     p_act [NSLOT];
    longint p_px [NSLOT], p_py [NSLOT], p_vx [NSLOT], p_vy [NSLOT];
    longint p_life [NSLOT], p_fade [NSLOT];
    bit     p_imp [NSLOT];
    longint p_grp [NSLOT];
    longint imp_cnt, boot_cnt, grp_next, live_tot, burst_ptr;
    bit     done_flag;

    beat_t  pending_beats [$];
    int     mismatches;
    int     beats_seen;
    int     items_sent;
    int     settings_used;
    int     send_idle;
    int     recv_stall;
    longint cycles;

    dir_row_t dir_tab [0:17] = '{
        '{-1, '{ppe_pkg::CMD_TICK, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, 5'sd0}, 32},
        '{-1, '{CMD_UNUSED, 16'sd5, 16'sd5, 1'b0, 16'sd1, 16'sd1, 5'sd1}, 0},
        '{-1, '{ppe_pkg::CMD_BURST, 16'sh7fff, 16'sh7fff, 1'b1, 16'sh7fff, 16'sh7fff,
                5'sd8}, 1},
        '{-1, '{ppe_pkg::CMD_BURST, -16'sh8000, -16'sh8000, 1'b0, -16'sh8000,
                -16'sh8000, -5'sd8}, 1},
        '{-1, '{ppe_pkg::CMD_TICK, 16'sh7fff, -16'sh8000, 1'b0, 16'sh7fff, -16'sh8000,
                -5'sd8}, 32},
        '{-1, '{ppe_pkg::CMD_TICK, -16'sh8000, 16'sh7fff, 1'b0, -16'sh8000, 16'sh7fff,
                5'sd8}, 32},
        '{-1, '{ppe_pkg::CMD_TICK, 16'sd100, -16'sd100, 1'b1, 16'sd7, -16'sd7,
                5'sd3}, 32},
        '{-1, '{ppe_pkg::CMD_TICK, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 5'sd0}, 32},
        '{-1, '{ppe_pkg::CMD_RESTART, 16'sd1, 16'sd1, 1'b0, 16'sd1, 16'sd1, 5'sd1}, 0},
        '{-1, '{ppe_pkg::CMD_TICK, 16'sh5555, 16'shaaaa, 1'b0, 16'shaaaa, 16'sh5555,
                5'sb10101}, 32},
        '{-1, '{ppe_pkg::CMD_BURST, 16'sd3, 16'sd4, 1'b0, 16'sd5, 16'sd6,
                5'sb01010}, 1},
        '{2, '{ppe_pkg::CMD_RESTART, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 5'sd0}, 0},
        '{-1, '{ppe_pkg::CMD_BURST, 16'sd10, 16'sd20, 1'b0, 16'sd30, 16'sd40,
                5'sd2}, 1},
        '{-1, '{ppe_pkg::CMD_BURST, 16'sd11, 16'sd21, 1'b0, 16'sd31, 16'sd41,
                5'sd4}, 1},
        '{-1, '{ppe_pkg::CMD_BURST, 16'sd12, 16'sd22, 1'b0, 16'sd32, 16'sd42,
                5'sd6}, 0},
        '{-1, '{ppe_pkg::CMD_TICK, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 5'sd0}, 2},
        '{0, '{ppe_pkg::CMD_TICK, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 5'sd0}, 0},
        '{63, '{ppe_pkg::CMD_TICK, 16'sd9, 16'sd9, 1'b0, 16'sd9, 16'sd9, -5'sd1}, 32}
    };

    function automatic longint clamp_w(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint pool_size_now();
        return r_slots > NSLOT ? NSLOT : r_slots;
    endfunction

    function automatic void clear_pool_model();
        for (int k = 0; k < NSLOT; k++)
        begin
            p_act[k] = 1'b0;
            p_px[k] = 0; p_py[k] = 0; p_vx[k] = 0; p_vy[k] = 0;
            p_life[k] = 0; p_fade[k] = 0; p_imp[k] = 1'b0; p_grp[k] = 0;
        end
        imp_cnt = 0;
        boot_cnt = 0;
        grp_next = 1;
        live_tot = 0;
        done_flag = 1'b0;
        burst_ptr = 0;
    endfunction

    function automatic void spawn_particle(int k, ppe_pkg::item_t it);
        p_life[k] = 1024;
        p_act[k] = 1'b1;
        p_px[k] = clamp_w(longint'(it.emitter_x) * (longint'(1) <<< FRAC), 24);
        p_py[k] = clamp_w(longint'(it.emitter_y) * (longint'(1) <<< FRAC), 24);
        p_imp[k] = (imp_cnt == 0);
        p_vx[k] = clamp_w(r_bvx + longint'(it.rand_vel_x), 16);
        p_vy[k] = clamp_w(r_bvy + longint'(it.rand_vel_y), 16);
        p_fade[k] = clamp_w(r_fade + longint'(it.rand_fade), 11);
        p_grp[k] = grp_next;
        grp_next++;
        if (grp_next >= 10)
            grp_next = 2;
    endfunction

    function automatic beat_t slot_report(int k, bit is_last);
        beat_t b;
        b = '0;
        b.slot = 5'(k);
        b.is_active = p_act[k];
        if (p_act[k])
        begin
            b.pos_x = 24'(p_px[k]);
            b.pos_y = 24'(p_py[k]);
            b.life_left = 12'(p_life[k]);
            b.second_colour = p_imp[k];
            b.blend_group = 4'(p_grp[k]);
        end
        b.live_count = 8'(live_tot);
        b.finished = done_flag;
        b.last = is_last;
        return b;
    endfunction

    // Advances the pool copy by one command and queues the beats it yields.
    function automatic int predict_pool_step(ppe_pkg::item_t it);
        longint n;
        bit     free_taken;
        n = pool_size_now();
        free_taken = 1'b0;
        case (it.cmd)
            ppe_pkg::CMD_RESTART:
            begin
                clear_pool_model();
                return 0;
            end
            ppe_pkg::CMD_BURST:
            begin
                if (burst_ptr >= n)
                    return 0;
                if (!p_act[burst_ptr])
                    live_tot = live_tot + 1 > 64 ? 64 : live_tot + 1;
                spawn_particle(int'(burst_ptr), it);
                imp_cnt++;
                if (imp_cnt > r_impp)
                    imp_cnt = 0;
                pending_beats.push_back(slot_report(int'(burst_ptr), 1'b1));
                burst_ptr++;
                return 1;
            end
            ppe_pkg::CMD_TICK:
            begin
                for (int k = 0; k < n; k++)
                begin
                    if (p_act[k])
                    begin
                        p_px[k] = clamp_w(p_px[k] + p_vx[k], 24);
                        p_py[k] = clamp_w(p_py[k] + p_vy[k], 24);
                        p_life[k] = clamp_w(p_life[k] - p_fade[k], 12);
                        p_vy[k] = clamp_w(p_vy[k] + r_grav, 16);
                        if (p_life[k] <= 0)
                        begin
                            p_act[k] = 1'b0;
                            live_tot = live_tot - 1 < -64 ? -64 : live_tot - 1;
                        end
                    end
                    else if (!it.stop_generation && boot_cnt == 0 && !free_taken
                             && !r_mode)
                    begin
                        free_taken = 1'b1;
                        spawn_particle(k, it);
                        live_tot = live_tot + 1 > 64 ? 64 : live_tot + 1;
                    end
                end
                imp_cnt++;
                boot_cnt++;
                if (imp_cnt > r_impp)
                    imp_cnt = 0;
                if (boot_cnt > r_boot)
                    boot_cnt = 0;
                if (live_tot == 0)
                    done_flag = 1'b1;
                for (int k = 0; k < n; k++)
                    pending_beats.push_back(slot_report(k, k == n - 1));
                return int'(n);
            end
            default:
                return 0;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d beats outstanding", cycles,
                     pending_beats.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: check each accepted beat, then decide the next ready.
    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            beats_seen++;
            got = '{rsp_ch.slot, rsp_ch.is_active, rsp_ch.pos_x, rsp_ch.pos_y,
                    rsp_ch.life_left, rsp_ch.second_colour, rsp_ch.blend_group,
                    rsp_ch.live_count, rsp_ch.finished, rsp_ch.last};
            if (pending_beats.size() == 0)
                report_mismatch("unexpected beat, slot", got.slot, 0);
            else
            begin
                want = pending_beats.pop_front();
                if (got.slot !== want.slot)
                    report_mismatch("slot", got.slot, want.slot);
                if (got.is_active !== want.is_active)
                    report_mismatch("is_active", got.is_active, want.is_active);
                if (got.pos_x !== want.pos_x)
                    report_mismatch("pos_x", got.pos_x, want.pos_x);
                if (got.pos_y !== want.pos_y)
                    report_mismatch("pos_y", got.pos_y, want.pos_y);
                if (got.life_left !== want.life_left)
                    report_mismatch("life_left", got.life_left, want.life_left);
                if (got.second_colour !== want.second_colour)
                    report_mismatch("second_colour", got.second_colour,
                                    want.second_colour);
                if (got.blend_group !== want.blend_group)
                    report_mismatch("blend_group", got.blend_group, want.blend_group);
                if (got.live_count !== want.live_count)
                    report_mismatch("live_count", got.live_count, want.live_count);
                if (got.finished !== want.finished)
                    report_mismatch("finished", got.finished, want.finished);
                if (got.last !== want.last)
                    report_mismatch("last", got.last, want.last);
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_command(ppe_pkg::item_t it, int n_beats);
        int n;
        if ($urandom_range(99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd <= it.cmd;
        req_ch.emitter_x <= it.emitter_x;
        req_ch.emitter_y <= it.emitter_y;
        req_ch.stop_generation <= it.stop_generation;
        req_ch.rand_vel_x <= it.rand_vel_x;
        req_ch.rand_vel_y <= it.rand_vel_y;
        req_ch.rand_fade <= it.rand_fade;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
        n = predict_pool_step(it);
        if (n_beats >= 0 && n != n_beats)
            report_mismatch("beat count of table row", n, n_beats);
    endtask

    // Lets the block go quiet: no command pending and every beat returned.
    task automatic drain_block();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            ppe_pkg::CFG_EMIT_MODE:    r_mode = val[0];
            ppe_pkg::CFG_SLOTS_IN_USE: r_slots = longint'(val[5:0]);
            ppe_pkg::CFG_BASE_VEL_X:   r_bvx = longint'($signed(val));
            ppe_pkg::CFG_BASE_VEL_Y:   r_bvy = longint'($signed(val));
            ppe_pkg::CFG_FADE_BASE:    r_fade = longint'(val[9:0]);
            ppe_pkg::CFG_GRAVITY_STEP: r_grav = longint'($signed(val[8:0]));
            ppe_pkg::CFG_BOOT_PERIOD:  r_boot = longint'(val[7:0]);
            default:                   r_impp = longint'(val[7:0]);
        endcase
    endtask

    task automatic load_setting(logic mode, logic [15:0] slots, logic [15:0] bvx,
                                logic [15:0] bvy, logic [15:0] fade, logic [15:0] grav,
                                logic [15:0] boot, logic [15:0] impp);
        write_reg(ppe_pkg::CFG_EMIT_MODE, {15'd0, mode});
        write_reg(ppe_pkg::CFG_SLOTS_IN_USE, slots);
        write_reg(ppe_pkg::CFG_BASE_VEL_X, bvx);
        write_reg(ppe_pkg::CFG_BASE_VEL_Y, bvy);
        write_reg(ppe_pkg::CFG_FADE_BASE, fade);
        write_reg(ppe_pkg::CFG_GRAVITY_STEP, grav);
        write_reg(ppe_pkg::CFG_BOOT_PERIOD, boot);
        write_reg(ppe_pkg::CFG_IMP_PERIOD, impp);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [15:0] pick_coord();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'h7fff;
        if (r == 1)
            return 16'h8000;
        return 16'($urandom);
    endfunction

    function automatic ppe_pkg::item_t random_command();
        ppe_pkg::item_t it;
        int             r;
        r = $urandom_range(99);
        it.cmd = r < 60 ? ppe_pkg::CMD_TICK :
                 (r < 85 ? ppe_pkg::CMD_BURST :
                 (r < 94 ? ppe_pkg::CMD_RESTART : CMD_UNUSED));
        it.emitter_x = pick_coord();
        it.emitter_y = pick_coord();
        it.stop_generation = ($urandom_range(3) == 0);
        it.rand_vel_x = pick_coord();
        it.rand_vel_y = pick_coord();
        it.rand_fade = 5'($signed($urandom_range(16)) - 8);
        return it;
    endfunction

    task automatic run_random_phase(int idle, int stall, int count);
        send_idle = idle;
        recv_stall = stall;
        for (int i = 0; i < count; i++)
            send_command(random_command(), -1);
        drain_block();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ppe_pkg::CFG_EMIT_MODE;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = ppe_pkg::CMD_TICK;
        req_ch.emitter_x = '0;
        req_ch.emitter_y = '0;
        req_ch.stop_generation = 1'b0;
        req_ch.rand_vel_x = '0;
        req_ch.rand_vel_y = '0;
        req_ch.rand_fade = '0;
        rsp_ch.ready = 1'b0;
        mismatches = 0;
        beats_seen = 0;
        items_sent = 0;
        settings_used = 1;
        send_idle = 0;
        recv_stall = 0;
        cycles = 0;
        r_mode = 1'b0;
        r_slots = 32;
        r_bvx = 0;
        r_bvy = 0;
        r_fade = 16;
        r_grav = 0;
        r_boot = 0;
        r_impp = 0;
        clear_pool_model();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].new_slots >= 0)
            begin
                drain_block();
                write_reg(ppe_pkg::CFG_SLOTS_IN_USE, 16'(dir_tab[i].new_slots));
                cfg_we <= 1'b0;
                settings_used++;
            end
            send_command(dir_tab[i].it, dir_tab[i].n_beats);
        end
        drain_block();

        load_setting(1'b0, 16'd32, 16'h7fff, 16'h8000, 16'd0, 16'h00ff, 16'd0, 16'd0);
        run_random_phase(0, 0, PHASE_LEN);
        load_setting(1'b1, 16'd5, 16'h8000, 16'h7fff, 16'd1023, 16'h0100, 16'd255,
                     16'd255);
        run_random_phase(83, 0, PHASE_LEN);
        load_setting(1'b0, 16'd63, 16'($urandom), 16'($urandom), 16'd40,
                     16'($urandom_range(511)), 16'd3, 16'd2);
        run_random_phase(0, 83, PHASE_LEN);
        load_setting(1'b0, 16'd0, 16'd300, 16'hff00, 16'd100, 16'd7, 16'd1, 16'd1);
        run_random_phase(37, 37, 8);
        load_setting(1'b0, 16'd12, 16'($urandom), 16'($urandom), 16'd150, 16'h01f8,
                     16'd1, 16'd3);
        run_random_phase(37, 37, PHASE_LEN);

        $display("Sent %0d commands and checked %0d result beats", items_sent, beats_seen);
        $display("across %0d register settings, %0d mismatches", settings_used, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

### particle_pool_emitter_tick.f
hdl/ppe_pkg.sv
hdl/ppe_if.sv
hdl/ppe_cell.sv
hdl/ppe_slot_unit.sv
hdl/particle_pool_emitter_tick.sv
tb/particle_pool_emitter_tick_test.sv
